>>> design/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types, constants and functions of the SHA-256 hasher
// Round constants, initial hash values, sequencer states and round helpers.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef logic [31:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t rotr(input word_t v, input int unsigned s);
        rotr = (v >> s) | (v << (32 - s));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> design/sha_stream_if.sv
// ----------------------------------------------------------------------------
// sha_stream_if: valid/ready channels of the SHA-256 hasher
// One interface for message bytes and one for digest words.
// ----------------------------------------------------------------------------
interface sha_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> design/sha_round.sv
// ----------------------------------------------------------------------------
// sha_round: one SHA-256 compression round and message schedule step
// Holds the working variables and a 16-word schedule window; one round a cycle while step is high.
// ----------------------------------------------------------------------------
module sha_round
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,        // start a block
    input  logic                 step,        // run one round
    input  logic [5:0]           round,
    input  sha_pkg::word_t       blk_word,    // schedule word for rounds 0..15
    input  sha_pkg::word_t       h_in [8],
    output sha_pkg::word_t       v_out [8]
);

    sha_pkg::word_t v_reg [8];
    sha_pkg::word_t w_reg [16];
    sha_pkg::word_t w_cur;
    sha_pkg::word_t t1;
    sha_pkg::word_t t2;
    sha_pkg::word_t big0;
    sha_pkg::word_t big1;
    sha_pkg::word_t ch;
    sha_pkg::word_t maj;

    always_comb
    begin
        if (round[5:4] == 2'b00)
        begin
            w_cur = blk_word;
        end
        else
        begin
            w_cur = sha_pkg::sig1(w_reg[14]) + w_reg[9] + sha_pkg::sig0(w_reg[1]) + w_reg[0];
        end
        big1 = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
             ^ sha_pkg::rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + sha_pkg::ROUND_K[round] + w_cur;
        big0 = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
             ^ sha_pkg::rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '{default: '0};
            w_reg <= '{default: '0};
        end
        else if (load)
        begin
            v_reg <= h_in;
        end
        else if (step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_cur;
        end
    end

    assign v_out = v_reg;

endmodule

>>> design/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher: SHA-256 digest over a byte stream
// Packs bytes into a 64-byte block memory, compresses each full block with a
// shared round unit, pads on end of message and emits eight digest words.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                 | handshake
//  in_ch    | in  | data_byte[8], has_byte, end_of_message  | valid/ready
//  out_ch   | out | digest_word[32], word_index[3], last_word | valid/ready
//
//  A full block goes through a load, 64 rounds and an add, one round per
//  cycle in the shared round unit, with each word fetched from the block
//  memory ahead of its round so that word fetch overlaps the rounds.
//  End of message adds padding (up to 64 byte writes, one per cycle, from the
//  single write port of the block memory), one or two blocks, then 8 words.
//  Reset (rst_n low, asynchronous) returns the hash to the initial values.
//  in_ch.ready is low while a block or digest is in progress; a stalled
//  out_ch holds the current word.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
(
    input  logic      clk,
    input  logic      rst_n,
    sha_byte_if.sink     in_ch,
    sha_digest_if.source out_ch
);

    sha_pkg::state_t state_reg, state_next;
    sha_pkg::word_t  h_reg [8];
    logic [63:0]     bits_reg;
    logic [6:0]      fill_reg;          // next byte slot in the block
    logic [5:0]      round_reg;
    logic            fin_reg;           // finalizing the message
    logic            lenblk_reg;        // current block carries the length
    logic [2:0]      widx_reg;

    // block memory, four byte lanes so one word is read per cycle
    logic [7:0]      mem0 [16];
    logic [7:0]      mem1 [16];
    logic [7:0]      mem2 [16];
    logic [7:0]      mem3 [16];
    sha_pkg::word_t  rd_word;
    logic [3:0]      rd_addr;

    logic            wr_en;
    logic [5:0]      wr_addr;
    logic [7:0]      wr_data;
    logic            acc;
    logic            rnd_load;
    logic            rnd_step;
    sha_pkg::word_t  v_out [8];
    sha_pkg::word_t  blk_word;
    logic [5:0]      pad_pos;

    assign acc = in_ch.valid && in_ch.ready;
    assign pad_pos = fill_reg[5:0];

    // next round's word address: fetch in the cycle before the round
    always_comb
    begin
        if (state_reg == sha_pkg::ST_LOAD)
        begin
            rd_addr = 4'd0;
        end
        else
        begin
            rd_addr = round_reg[3:0] + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            unique case (wr_addr[1:0])
                2'd0: mem0[wr_addr[5:2]] <= wr_data;
                2'd1: mem1[wr_addr[5:2]] <= wr_data;
                2'd2: mem2[wr_addr[5:2]] <= wr_data;
                default: mem3[wr_addr[5:2]] <= wr_data;
            endcase
        end
        rd_word <= {mem0[rd_addr], mem1[rd_addr], mem2[rd_addr], mem3[rd_addr]};
    end

    // length sits in the last two words of a length block
    always_comb
    begin
        if (lenblk_reg && round_reg == 6'd14)
        begin
            blk_word = bits_reg[63:32];
        end
        else if (lenblk_reg && round_reg == 6'd15)
        begin
            blk_word = bits_reg[31:0];
        end
        else
        begin
            blk_word = rd_word;
        end
    end

    sha_round u_round
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (rnd_load),
        .step     (rnd_step),
        .round    (round_reg),
        .blk_word (blk_word),
        .h_in     (h_reg),
        .v_out    (v_out)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    if (in_ch.has_byte && fill_reg == 7'd63)
                    begin
                        state_next = sha_pkg::ST_LOAD;
                    end
                    else if (in_ch.end_of_message)
                    begin
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD:
            begin
                // the slot before the length closes the length block, even
                // when the 0x80 marker itself lands there
                if (pad_pos == 6'd63 || (fin_reg && pad_pos == 6'd55))
                begin
                    state_next = sha_pkg::ST_LOAD;
                end
            end
            sha_pkg::ST_LOAD:  state_next = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_ADD;
                end
            end
            sha_pkg::ST_ADD:
            begin
                if (lenblk_reg)
                begin
                    state_next = sha_pkg::ST_EMIT;
                end
                else if (fin_reg)
                begin
                    state_next = sha_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_EMIT:
            begin
                if (out_ch.ready && widx_reg == 3'd7)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ch.ready = (state_reg == sha_pkg::ST_IDLE);
        out_ch.valid = (state_reg == sha_pkg::ST_EMIT);
        rnd_load = (state_reg == sha_pkg::ST_LOAD);
        rnd_step = (state_reg == sha_pkg::ST_ROUND);
        wr_en = 1'b0;
        wr_addr = pad_pos;
        wr_data = 8'h00;
        if (state_reg == sha_pkg::ST_IDLE && acc && in_ch.has_byte)
        begin
            wr_en = 1'b1;
            wr_data = in_ch.data_byte;
        end
        else if (state_reg == sha_pkg::ST_PAD)
        begin
            wr_en = 1'b1;
            // fill_reg[6] marks that the 0x80 marker is already written
            wr_data = fill_reg[6] ? 8'h00 : sha_pkg::PAD_BYTE;
        end
    end

    assign out_ch.digest_word = h_reg[widx_reg];
    assign out_ch.word_index  = widx_reg;
    assign out_ch.last_word   = (widx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha_pkg::ST_IDLE;
            h_reg      <= sha_pkg::INIT_H;
            bits_reg   <= '0;
            fill_reg   <= '0;
            round_reg  <= '0;
            fin_reg    <= 1'b0;
            lenblk_reg <= 1'b0;
            widx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                sha_pkg::ST_IDLE:
                begin
                    if (acc)
                    begin
                        fin_reg <= in_ch.end_of_message;
                        if (in_ch.has_byte)
                        begin
                            bits_reg <= bits_reg + 64'd8;
                            fill_reg <= (fill_reg == 7'd63) ? 7'd0 : fill_reg + 7'd1;
                        end
                    end
                end
                sha_pkg::ST_PAD:
                begin
                    // bit 6 set once the marker is in; low bits walk the slots
                    if (pad_pos == 6'd63)
                    begin
                        fill_reg <= 7'b1000000;
                    end
                    else if (pad_pos == 6'd55)
                    begin
                        fill_reg <= 7'b1000000;
                        lenblk_reg <= 1'b1;
                    end
                    else
                    begin
                        fill_reg <= {1'b1, pad_pos + 6'd1};
                    end
                end
                sha_pkg::ST_LOAD:  round_reg <= '0;
                sha_pkg::ST_ROUND: round_reg <= round_reg + 6'd1;
                sha_pkg::ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_out[i];
                    end
                    if (!fin_reg)
                    begin
                        fill_reg <= '0;
                    end
                    widx_reg <= '0;
                end
                sha_pkg::ST_EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7)
                        begin
                            h_reg      <= sha_pkg::INIT_H;
                            bits_reg   <= '0;
                            fill_reg   <= '0;
                            fin_reg    <= 1'b0;
                            lenblk_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // digest goes out in order, one word per handshake
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !out_ch.last_word |=> out_ch.valid)
        else $error("digest burst broken");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input taken during digest");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha_pkg::ST_ROUND && round_reg == 6'd63 |=> state_reg == sha_pkg::ST_ADD)
        else $error("round count slip");

endmodule
